// ===== hdl/fbld_pkg.sv =====
// Shared constants and types of the framebuffer line drawer.
package fbld_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 96;
  localparam int ROW_BYTES     = (SCREEN_WIDTH + 3) / 4;
  localparam int STORE_BYTES   = ROW_BYTES * SCREEN_HEIGHT;
  localparam int ADDR_W        = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int COORD_W       = 8;
  localparam int SHADE_W       = 8;
  localparam int PIX_W         = 2;
  localparam int ERR_W         = 12;

  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  localparam logic [PIX_W-1:0] PIX_MAX = 2'd3;

  typedef struct packed {
    logic load;
    logic advance;
  } bres_ctl_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               done;
  } bres_pos_t;

endpackage

// ===== hdl/fbld_store.sv =====
// Single-port byte store that holds the packed pixels.
module fbld_store (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [fbld_pkg::ADDR_W-1:0] addr_i,
  input  logic [7:0]                 wdata_i,
  output logic [7:0]                 rdata_o
);

  logic [7:0] mem_q [fbld_pkg::STORE_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/fbld_bres.sv =====
// Bresenham stepper that walks one point of a line per advance.
module fbld_bres (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fbld_pkg::bres_ctl_t         ctl_i,
  input  logic [fbld_pkg::COORD_W-1:0] x0_i,
  input  logic [fbld_pkg::COORD_W-1:0] y0_i,
  input  logic [fbld_pkg::COORD_W-1:0] x1_i,
  input  logic [fbld_pkg::COORD_W-1:0] y1_i,
  output fbld_pkg::bres_pos_t         pos_o
);

  localparam int EW = fbld_pkg::ERR_W;
  localparam int CW = fbld_pkg::COORD_W;

  logic [CW-1:0]        x_q, x_d, y_q, y_d, x1_q, y1_q;
  logic                 sx_neg_q, sy_neg_q;
  logic signed [EW-1:0] dx_q, dy_q, err_q;
  logic signed [EW-1:0] dx_d, dy_d, err_d;
  logic [CW-1:0]        diff_x, diff_y;
  logic signed [EW:0]   e2, dx_ext, dy_ext;
  logic                 step_x, step_y;

  always_comb begin
    diff_x = (x1_i > x0_i) ? (x1_i - x0_i) : (x0_i - x1_i);
    diff_y = (y1_i > y0_i) ? (y1_i - y0_i) : (y0_i - y1_i);
    dx_d   = signed'({{(EW - CW){1'b0}}, diff_x});
    dy_d   = -signed'({{(EW - CW){1'b0}}, diff_y});

    e2     = {err_q, 1'b0};
    dx_ext = {dx_q[EW-1], dx_q};
    dy_ext = {dy_q[EW-1], dy_q};
    step_x = (e2 >= dy_ext);
    step_y = (e2 <= dx_ext);
    err_d  = err_q + (step_x ? dy_q : '0) + (step_y ? dx_q : '0);
    x_d    = step_x ? (sx_neg_q ? x_q - 1'b1 : x_q + 1'b1) : x_q;
    y_d    = step_y ? (sy_neg_q ? y_q - 1'b1 : y_q + 1'b1) : y_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q      <= '0;
      y_q      <= '0;
      x1_q     <= '0;
      y1_q     <= '0;
      sx_neg_q <= 1'b0;
      sy_neg_q <= 1'b0;
      dx_q     <= '0;
      dy_q     <= '0;
      err_q    <= '0;
    end else if (ctl_i.load) begin
      x_q      <= x0_i;
      y_q      <= y0_i;
      x1_q     <= x1_i;
      y1_q     <= y1_i;
      sx_neg_q <= !(x0_i < x1_i);
      sy_neg_q <= !(y0_i < y1_i);
      dx_q     <= dx_d;
      dy_q     <= dy_d;
      err_q    <= dx_d + dy_d;
    end else if (ctl_i.advance) begin
      x_q   <= x_d;
      y_q   <= y_d;
      err_q <= err_d;
    end
  end

  assign pos_o.x    = x_q;
  assign pos_o.y    = y_q;
  assign pos_o.done = (x_q == x1_q) && (y_q == y1_q);

endmodule

// ===== hdl/framebuffer_line_drawer.sv =====
// Top level of the framebuffer line drawer: command sequencer and result register.
//
//   channel | direction | signals
//   --------+-----------+------------------------------------------------------
//   in      | input     | in_valid_i, in_stall_o, kind_i, start_x_i, start_y_i,
//           |           | end_x_i, end_y_i, shade_i
//   out     | output    | out_valid_o, out_stall_i, pixel_value_o
//
// A pixel draw or read passes the read, write and response states, an off-screen one skipping
// the write; a line passes the read and write states for each on-screen point, set by the
// read-modify-write on the single store port. A clear writes every byte, one byte per cycle.
// After reset the same clearing pass runs with the input stalled.
// A new command beat is taken while the previous result still waits on a stalled output.
module framebuffer_line_drawer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   kind_i,
  input  logic [fbld_pkg::COORD_W-1:0] start_x_i,
  input  logic [fbld_pkg::COORD_W-1:0] start_y_i,
  input  logic [fbld_pkg::COORD_W-1:0] end_x_i,
  input  logic [fbld_pkg::COORD_W-1:0] end_y_i,
  input  logic [fbld_pkg::SHADE_W-1:0] shade_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [fbld_pkg::PIX_W-1:0]   pixel_value_o
);

  localparam int AW = fbld_pkg::ADDR_W;
  localparam int CW = fbld_pkg::COORD_W;
  localparam int PW = fbld_pkg::PIX_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RD    = 5'b00010,
    S_WR    = 5'b00100,
    S_CLEAR = 5'b01000,
    S_RESP  = 5'b10000
  } state_e;

  function automatic logic [PW-1:0] get_pix(logic [7:0] b, logic [1:0] p);
    logic [PW-1:0] v;
    case (p)
      2'd0:    v = b[7:6];
      2'd1:    v = b[5:4];
      2'd2:    v = b[3:2];
      default: v = b[1:0];
    endcase
    return v;
  endfunction

  function automatic logic [7:0] put_pix(logic [7:0] b, logic [1:0] p, logic [PW-1:0] v);
    logic [7:0] r;
    r = b;
    case (p)
      2'd0:    r[7:6] = v;
      2'd1:    r[5:4] = v;
      2'd2:    r[3:2] = v;
      default: r[1:0] = v;
    endcase
    return r;
  endfunction

  state_e              state_q, state_d;
  logic [1:0]          kind_q;
  logic [PW-1:0]       shade_q;
  logic [PW-1:0]       value_q;
  logic [AW-1:0]       addr_q;
  logic [AW-1:0]       clr_cnt_q;
  logic                clr_cmd_q;
  logic                out_valid_q;
  logic [PW-1:0]       pixel_q;

  logic                accept;
  logic                on_screen;
  logic                clr_last;
  logic                resp_free;
  logic [AW-1:0]       pix_addr;
  logic [AW-1:0]       mem_addr;
  logic                mem_we;
  logic [7:0]          mem_wdata;
  logic [7:0]          mem_rdata;
  logic [CW-1:0]       line_x1, line_y1;
  fbld_pkg::bres_ctl_t bres_ctl;
  fbld_pkg::bres_pos_t pos;

  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign on_screen = ({1'b0, pos.x} < (CW + 1)'(fbld_pkg::SCREEN_WIDTH)) &&
                     ({1'b0, pos.y} < (CW + 1)'(fbld_pkg::SCREEN_HEIGHT));
  assign pix_addr  = AW'(AW'(pos.y) * AW'(fbld_pkg::ROW_BYTES)) + AW'(pos.x[CW-1:2]);
  assign clr_last  = (clr_cnt_q == AW'(fbld_pkg::STORE_BYTES - 1));
  assign resp_free = !out_valid_q || !out_stall_i;
  assign line_x1   = (kind_i == fbld_pkg::KIND_LINE) ? end_x_i : start_x_i;
  assign line_y1   = (kind_i == fbld_pkg::KIND_LINE) ? end_y_i : start_y_i;

  always_comb begin
    state_d          = state_q;
    bres_ctl.load    = 1'b0;
    bres_ctl.advance = 1'b0;
    mem_we           = 1'b0;
    mem_addr         = pix_addr;
    mem_wdata        = put_pix(mem_rdata, pos.x[1:0], shade_q);
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          bres_ctl.load = 1'b1;
          state_d = (kind_i == fbld_pkg::KIND_CLEAR) ? S_CLEAR : S_RD;
        end
      end
      S_RD: begin
        if (on_screen) begin
          state_d = S_WR;
        end else if (pos.done) begin
          state_d = S_RESP;
        end else begin
          bres_ctl.advance = 1'b1;
        end
      end
      S_WR: begin
        mem_addr = addr_q;
        mem_we   = (kind_q != fbld_pkg::KIND_READ);
        if (pos.done) begin
          state_d = S_RESP;
        end else begin
          bres_ctl.advance = 1'b1;
          state_d = S_RD;
        end
      end
      S_CLEAR: begin
        mem_addr  = clr_cnt_q;
        mem_we    = 1'b1;
        mem_wdata = '0;
        if (clr_last) begin
          state_d = clr_cmd_q ? S_RESP : S_IDLE;
        end
      end
      S_RESP: begin
        if (resp_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      clr_cmd_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && (kind_i == fbld_pkg::KIND_CLEAR)) begin
        clr_cnt_q <= '0;
        clr_cmd_q <= 1'b1;
      end else if (state_q == S_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (state_q == S_RESP && resp_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_i;
      shade_q <= (shade_i > fbld_pkg::SHADE_W'(fbld_pkg::PIX_MAX)) ?
                 fbld_pkg::PIX_MAX : shade_i[PW-1:0];
      value_q <= '0;
    end
    if (state_q == S_RD) begin
      addr_q <= pix_addr;
    end
    if (state_q == S_WR && kind_q == fbld_pkg::KIND_READ) begin
      value_q <= get_pix(mem_rdata, pos.x[1:0]);
    end
    if (state_q == S_RESP && resp_free) begin
      pixel_q <= value_q;
    end
  end

  fbld_bres u_bres (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (bres_ctl),
    .x0_i   (start_x_i),
    .y0_i   (start_y_i),
    .x1_i   (line_x1),
    .y1_i   (line_y1),
    .pos_o  (pos)
  );

  fbld_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign pixel_value_o = pixel_q;

`ifndef SYNTH
  // A store access phase always follows the address phase of the same point.
  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WR |-> $past(state_q == S_RD))
    else $error("write phase without preceding read phase");

  // The store is only written while clearing or in the write phase of a draw.
  a_we_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_CLEAR || (state_q == S_WR && kind_q != fbld_pkg::KIND_READ)))
    else $error("store written outside a drawing or clearing phase");

  // An accepted command beat always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE)
    else $error("accepted beat did not start a command");

  // Leaving the response state always presents a result.
  a_resp_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RESP |=> state_q == S_RESP || (state_q == S_IDLE && out_valid_o))
    else $error("command finished without a result");
`endif

endmodule
